>>> hw/rtl/cau_pkg.sv
`default_nettype none

package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } cau_op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // quotient bits kept by the divider, and width of the scaled dividend
  localparam int DivSteps = 32;
  localparam int DivXW    = 80;

  typedef struct packed {
    logic        [1:0]  req_type;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } cau_req_t;

  typedef struct packed {
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic        [1:0]  status;
  } cau_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/cau_div_lane.sv
`default_nettype none

module cau_div_lane import cau_pkg::*; (
  input  logic             clk,
  input  logic [DivXW-1:0] x,
  input  logic [63:0]      den,
  output logic [31:0]      q,
  output logic             big
);

  logic [63:0]         rem [0:DivSteps];
  logic [31:0]         low [0:DivSteps];
  logic [DivSteps-1:0] quo [0:DivSteps];
  logic [63:0]         dv  [0:DivSteps];
  logic                ovr [0:DivSteps];

  // quotient of 2^32 or more saturates, so only the low word of bits is formed
  always_ff @(posedge clk) begin
    ovr[0] <= {16'h0, x[DivXW-1:32]} >= den;
    rem[0] <= {16'h0, x[DivXW-1:32]};
    low[0] <= x[31:0];
    quo[0] <= '0;
    dv[0]  <= den;
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [64:0] t;
    logic [64:0] d;
    logic        ge;

    always_comb begin
      t  = {rem[k], low[k][31]};
      d  = t - {1'b0, dv[k]};
      ge = t >= {1'b0, dv[k]};
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? d[63:0] : t[63:0];
      low[k+1] <= {low[k][30:0], 1'b0};
      quo[k+1] <= {quo[k][DivSteps-2:0], ge};
      dv[k+1]  <= dv[k];
      ovr[k+1] <= ovr[k];
    end
  end

  assign q   = quo[DivSteps];
  assign big = ovr[DivSteps];

endmodule

`default_nettype wire

>>> hw/rtl/complex_arithmetic_unit_top.sv
`default_nettype none

// Complex add, subtract, multiply and divide on signed Q16.16 operands. A word
// is taken in every cycle (busy never rises) and the results appear in order,
// each with result_valid high for one cycle only; the receiver cannot stall. The
// pipeline holds the divider, which forms one quotient bit per pipeline stage
// over 32 stages after one loading stage, behind four stages of products, sums,
// magnitudes and scaling, and one output stage of saturation.
module complex_arithmetic_unit_top import cau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  cau_req_t req,
  output logic     result_valid,
  output cau_res_t res
);

  typedef struct packed {
    cau_op_t     op;
    logic        zero;
    logic        nr;
    logic        ni;
    logic [63:0] mr;
    logic [63:0] mi;
  } side_t;

  function automatic logic [32:0] sat32(input logic neg, input logic [63:0] mag);
    logic [63:0] negm;
    begin
      negm = ~mag + 64'd1;
      if (neg) begin
        if (mag > 64'h8000_0000) return {1'b1, 32'h8000_0000};
        return {1'b0, negm[31:0]};
      end
      if (mag > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
      return {1'b0, mag[31:0]};
    end
  endfunction

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: products, and sums or differences for add and subtract
  logic               v1;
  cau_op_t            op1;
  logic               zero1;
  logic signed [63:0] prr, pii, pir, pri, pbr, pbi;
  logic signed [32:0] sr1, si1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    op1   <= cau_op_t'(req.req_type);
    zero1 <= (req.b_real == 32'sd0) && (req.b_imag == 32'sd0);
    prr   <= req.a_real * req.b_real;
    pii   <= req.a_imag * req.b_imag;
    pir   <= req.a_imag * req.b_real;
    pri   <= req.a_real * req.b_imag;
    pbr   <= req.b_real * req.b_real;
    pbi   <= req.b_imag * req.b_imag;
    if (cau_op_t'(req.req_type) == OP_ADD) begin
      sr1 <= req.a_real + req.b_real;
      si1 <= req.a_imag + req.b_imag;
    end else begin
      sr1 <= req.a_real - req.b_real;
      si1 <= req.a_imag - req.b_imag;
    end
  end

  // stage 2: sums and divisor
  logic               v2;
  cau_op_t            op2;
  logic               zero2;
  logic signed [64:0] re2, im2;
  logic [63:0]        den2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    op2   <= op1;
    zero2 <= zero1;
    den2  <= unsigned'(pbr) + unsigned'(pbi);
    case (op1)
      OP_MUL: begin
        re2 <= prr - pii;
        im2 <= pir + pri;
      end
      OP_DIV: begin
        re2 <= prr + pii;
        im2 <= pir - pri;
      end
      default: begin
        re2 <= sr1;
        im2 <= si1;
      end
    endcase
  end

  // stage 3: sign and magnitude
  logic        v3;
  cau_op_t     op3;
  logic        zero3, nr3, ni3;
  logic [63:0] mr3, mi3, den3;
  logic [64:0] negr, negi;

  always_comb begin
    negr = -re2;
    negi = -im2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    op3   <= op2;
    zero3 <= zero2;
    den3  <= den2;
    nr3   <= re2[64];
    ni3   <= im2[64];
    mr3   <= re2[64] ? negr[63:0] : re2[63:0];
    mi3   <= im2[64] ? negi[63:0] : im2[63:0];
  end

  // stage 4: scaling
  logic             v4;
  side_t            s4;
  logic [DivXW-1:0] xr4, xi4;
  logic [63:0]      den4;
  logic [64:0]      rndr, rndi;

  always_comb begin
    rndr = {1'b0, mr3} + 65'h8000;
    rndi = {1'b0, mi3} + 65'h8000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    s4.op   <= op3;
    s4.zero <= zero3;
    s4.nr   <= nr3;
    s4.ni   <= ni3;
    if (op3 == OP_MUL) begin
      s4.mr <= {15'h0, rndr[64:16]};
      s4.mi <= {15'h0, rndi[64:16]};
    end else begin
      s4.mr <= mr3;
      s4.mi <= mi3;
    end
    den4 <= den3;
    xr4  <= {mr3, 16'h0} + {17'h0, den3[63:1]};
    xi4  <= {mi3, 16'h0} + {17'h0, den3[63:1]};
  end

  // division lanes, with side data delayed alongside
  logic [31:0] qr, qi;
  logic        bigr, bigi;

  cau_div_lane u_div_re (
    .clk (clk),
    .x   (xr4),
    .den (den4),
    .q   (qr),
    .big (bigr)
  );

  cau_div_lane u_div_im (
    .clk (clk),
    .x   (xi4),
    .den (den4),
    .q   (qi),
    .big (bigi)
  );

  side_t sb  [0:DivSteps];
  logic  sbv [0:DivSteps];

  always_ff @(posedge clk) begin
    if (rst) begin
      sbv[0] <= 1'b0;
    end else begin
      sbv[0] <= v4;
    end
    sb[0] <= s4;
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        sbv[k+1] <= 1'b0;
      end else begin
        sbv[k+1] <= sbv[k];
      end
      sb[k+1] <= sb[k];
    end
  end

  // output stage: saturation and status
  side_t       sf;
  logic [63:0] fmr, fmi;
  logic [32:0] satr, sati;

  always_comb begin
    sf = sb[DivSteps];
    if (sf.op == OP_DIV) begin
      fmr = bigr ? 64'hFFFF_FFFF_FFFF_FFFF : {32'h0, qr};
      fmi = bigi ? 64'hFFFF_FFFF_FFFF_FFFF : {32'h0, qi};
    end else begin
      fmr = sf.mr;
      fmi = sf.mi;
    end
    satr = sat32(sf.nr, fmr);
    sati = sat32(sf.ni, fmi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= sbv[DivSteps];
    end
    if (sf.op == OP_DIV && sf.zero) begin
      res.res_real <= '0;
      res.res_imag <= '0;
      res.status   <= ST_DIV_ZERO;
    end else begin
      res.res_real <= satr[31:0];
      res.res_imag <= sati[31:0];
      res.status   <= (satr[32] || sati[32]) ? ST_OVERFLOW : ST_OK;
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
module tb_top;
  import cau_pkg::*;

  localparam int LATENCY = 38;
  localparam int MAX_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cau_req_t req = '0;
  logic result_valid;
  cau_res_t res;

  complex_arithmetic_unit_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .result_valid(result_valid), .res(res)
  );

  cau_req_t pending_words[$];
  cau_res_t expected_results[$];
  int idle_pct = 17;
  bit hold_off = 1'b0;
  int errors = 0;
  int cycles = 0;

  function automatic logic [31:0] saturate(input logic signed [127:0] v, inout bit ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // round to nearest, ties away from zero, on magnitude
  function automatic logic signed [127:0] div_round(input logic signed [127:0] n,
                                                   input logic signed [127:0] d);
    logic [127:0] mag;
    logic [127:0] q;
    mag = n < 0 ? -n : n;
    q = ((mag << 16) + (d >> 1)) / d;
    return n < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [127:0] mul_round(input logic signed [127:0] n);
    logic [127:0] mag;
    mag = n < 0 ? -n : n;
    mag = (mag + 128'h8000) >> 16;
    return n < 0 ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic cau_res_t complex_result(input cau_req_t w);
    cau_res_t r;
    bit ovf;
    logic signed [127:0] ar, ai, br, bi, nr, ni, den;
    ovf = 1'b0;
    ar = w.a_real;
    ai = w.a_imag;
    br = w.b_real;
    bi = w.b_imag;
    r.status = ST_OK;
    case (cau_op_t'(w.req_type))
      OP_ADD: begin
        r.res_real = saturate(ar + br, ovf);
        r.res_imag = saturate(ai + bi, ovf);
      end
      OP_SUB: begin
        r.res_real = saturate(ar - br, ovf);
        r.res_imag = saturate(ai - bi, ovf);
      end
      OP_MUL: begin
        r.res_real = saturate(mul_round(ar * br - ai * bi), ovf);
        r.res_imag = saturate(mul_round(ai * br + ar * bi), ovf);
      end
      default: begin
        if (br == 0 && bi == 0) begin
          r.res_real = '0;
          r.res_imag = '0;
          r.status = ST_DIV_ZERO;
        end else begin
          den = br * br + bi * bi;
          nr = ar * br + ai * bi;
          ni = ai * br - ar * bi;
          r.res_real = saturate(div_round(nr, den), ovf);
          r.res_imag = saturate(div_round(ni, den), ovf);
        end
      end
    endcase
    if (r.status == ST_OK && ovf) r.status = ST_OVERFLOW;
    return r;
  endfunction

  function automatic logic [31:0] random_part();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
      4: return 32'($signed($urandom_range(0, 255)) - 128);
      5: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'h20000);
      default: return $urandom;
    endcase
  endfunction

  function automatic cau_req_t make_word(input cau_op_t op, input logic [31:0] a0,
                                         input logic [31:0] a1, input logic [31:0] b0,
                                         input logic [31:0] b1);
    cau_req_t w;
    w.req_type = op;
    w.a_real = a0;
    w.a_imag = a1;
    w.b_real = b0;
    w.b_imag = b1;
    return w;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(complex_result(req));
        void'(pending_words.pop_front());
      end
      if (pending_words.size() > 0 && !hold_off &&
          $urandom_range(0, 99) >= idle_pct) begin
        req <= pending_words[0];
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word res=%h", $time, res);
        errors++;
      end else begin
        cau_res_t e;
        e = expected_results.pop_front();
        if (e.res_real !== res.res_real || e.res_imag !== res.res_imag ||
            e.status !== res.status) begin
          $display("%0t: mismatch expected re=%h im=%h st=%0d actual re=%h im=%h st=%0d",
                   $time, e.res_real, e.res_imag, e.status,
                   res.res_real, res.res_imag, res.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [31:0] edges[5];
    edges = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h00010000, 32'hffff0000};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int op = 0; op < 4; op++) begin
      pending_words.push_back(make_word(cau_op_t'(op), 32'h7fffffff, 32'h80000000,
                                        32'h7fffffff, 32'h80000000));
      pending_words.push_back(make_word(cau_op_t'(op), 32'h80000000, 32'h80000000,
                                        32'h80000000, 32'h80000000));
      pending_words.push_back(make_word(cau_op_t'(op), 32'h00018000, 32'hfffe8000,
                                        32'h00010000, 32'h00000001));
    end
    pending_words.push_back(make_word(OP_DIV, 32'h12345678, 32'h0, 32'h0, 32'h0));
    pending_words.push_back(make_word(OP_DIV, 32'h7fffffff, 32'h7fffffff, 32'h1, 32'h0));
    pending_words.push_back(make_word(OP_DIV, 32'h1, 32'h0, 32'h7fffffff, 32'h7fffffff));
    pending_words.push_back(make_word(OP_DIV, 32'h00010000, 32'h0, 32'h00030000, 32'h0));
    pending_words.push_back(make_word(OP_MUL, 32'h1, 32'h0, 32'h00008000, 32'h0));
    pending_words.push_back(make_word(OP_MUL, 32'hffffffff, 32'h0, 32'h00008000, 32'h0));
    pending_words.push_back(make_word(OP_MUL, 32'h0, 32'h0, 32'h0, 32'h0));
    wait_drained();
    // with every result back, the sender is held off, then released
    hold_off = 1'b1;
    repeat (LATENCY + 5) @(posedge clk);
    hold_off = 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 17 : (phase == 1) ? 53 : 0;
      for (int i = 0; i < 610; i++) begin
        cau_op_t op;
        op = cau_op_t'($urandom_range(0, 3));
        if (op == OP_DIV && $urandom_range(0, 19) == 0)
          pending_words.push_back(make_word(op, random_part(), random_part(),
                                            32'h0, 32'h0));
        else
          pending_words.push_back(make_word(op, random_part(), random_part(),
                                            random_part(), random_part()));
        if (i % 40 == 0) pending_words.push_back(make_word(op, edges[$urandom_range(0, 4)],
          edges[$urandom_range(0, 4)], edges[$urandom_range(0, 4)],
          edges[$urandom_range(0, 4)]));
      end
      wait_drained();
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
